>>> hw/rtl/lzhc_pkg.sv
package lzhc_pkg;
  localparam int BLOCK_BYTES_DEF = 16384;
  localparam int WINDOW_SPAN_DEF = 2047;
  localparam int RUN_KEEP_DEF    = 16;
  localparam int PAIR_BITS       = 16;
  localparam int LEN_W           = 15;
  localparam int POS_W           = 14;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_CLR    = 16'h0002,
    ST_PA     = 16'h0004,
    ST_PB     = 16'h0008,
    ST_HEAD   = 16'h0010,
    ST_CHK    = 16'h0020,
    ST_CA     = 16'h0040,
    ST_CB     = 16'h0080,
    ST_CMP    = 16'h0100,
    ST_LINK   = 16'h0200,
    ST_INS    = 16'h0400,
    ST_STAMP  = 16'h0800,
    ST_NEXT   = 16'h1000,
    ST_RD     = 16'h2000,
    ST_RDOUT  = 16'h4000,
    ST_HCLR   = 16'h8000
  } state_t;
endpackage

>>> hw/rtl/lz77_hash_chain_match_finder.sv
// LZ77 hash-chain match finder.
// Input channel: start with in_mode, in_data_byte, in_last_byte, in_read_index,
// taken when start is high and busy is low. mode 0 appends a byte; a byte
// with in_last_byte set ends the block and starts the search. mode 1 reads
// the stored result of one position.
// Result channel: out_valid strobes for one cycle with out_length and
// out_match_position, registered after a taken read has passed through ST_RD and
// ST_RDOUT. The receiver cannot stall; each strobe is one transaction.
// Loads can follow back to back; a read keeps the block busy through ST_RD and
// ST_RDOUT. The search walks the positions in order, skipping ahead inside long
// self-overlapping runs; bytes are compared through the single block memory
// port, and results are stamped one position per cycle. Its time is
// data dependent.
// At reset and at each search start the head table is cleared by a sweep over all
// 65536 entries and the result stores by a sweep over BLOCK_BYTES entries;
// busy stays high meanwhile. Reads during loading return the prior results.
module lz77_hash_chain_match_finder #(
  parameter int BLOCK_BYTES = lzhc_pkg::BLOCK_BYTES_DEF,
  parameter int WINDOW_SPAN = lzhc_pkg::WINDOW_SPAN_DEF,
  parameter int RUN_KEEP    = lzhc_pkg::RUN_KEEP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [13:0] in_read_index,
  output logic        out_valid,
  output logic [14:0] out_length,
  output logic [13:0] out_match_position
);
  localparam int AW = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;
  localparam int FW = AW + 1;
  localparam int HW = lzhc_pkg::PAIR_BITS;

  logic [7:0]    bmem [BLOCK_BYTES];
  logic [AW:0]   hmem [2**HW];
  logic [AW:0]   lmem [BLOCK_BYTES];
  logic [FW-1:0] rlen [BLOCK_BYTES];
  logic [AW-1:0] rsrc [BLOCK_BYTES];

  lzhc_pkg::state_t st_r;
  logic [FW-1:0] fill_r, p_r, a_r, b_r, n_r, best_r, k_r, rcnt_r;
  logic [AW:0]   c_r, hd_r;
  logic [AW-1:0] bsrc_r;
  logic [HW-1:0] key_r;
  logic [HW:0]   hc_r;
  logic [7:0]    bq, ba_r;
  logic [AW:0]   hq, lq;
  logic [FW-1:0] lq_len;
  logic [AW-1:0] lq_src;
  logic          done_r, rd_oor_r, ov_r;

  logic          bwe;
  logic [AW-1:0] bwa, bra;
  logic          hwe;
  logic [HW-1:0] hwa, hra;
  logic [AW:0]   hwd;
  logic          lwe;
  logic [AW-1:0] lwa, lra;
  logic          rwe;
  logic [AW-1:0] rwa, rra;
  logic [FW-1:0] rwl;
  logic [AW-1:0] rws;

  always_ff @(posedge clk) begin
    if (bwe) bmem[bwa] <= in_data_byte;
    bq <= bmem[bra];
    if (hwe) hmem[hwa] <= hwd;
    hq <= hmem[hra];
    if (lwe) lmem[lwa] <= hd_r;
    lq <= lmem[lra];
    if (rwe) begin
      rlen[rwa] <= rwl;
      rsrc[rwa] <= rws;
    end
    if (st_r == lzhc_pkg::ST_IDLE) begin
      lq_len <= rlen[rra];
      lq_src <= rsrc[rra];
    end
  end

  logic [FW-1:0] back_dist;
  logic [FW-1:0] stamp_pos;
  logic          valid_c;
  assign busy = (st_r != lzhc_pkg::ST_IDLE);
  assign back_dist = p_r - FW'(c_r[AW-1:0]);
  assign stamp_pos = p_r + k_r;

  always_comb begin
    bwe = 1'b0; bwa = fill_r[AW-1:0]; bra = a_r[AW-1:0];
    hwe = 1'b0; hwa = hc_r[HW-1:0]; hwd = '0; hra = key_r;
    lwe = 1'b0; lwa = p_r[AW-1:0]; lra = c_r[AW-1:0];
    rwe = 1'b0; rwa = rcnt_r[AW-1:0]; rwl = '0; rws = '0;
    rra = in_read_index[AW-1:0];
    valid_c = c_r[AW] && (back_dist < FW'(WINDOW_SPAN));
    unique case (st_r)
      lzhc_pkg::ST_IDLE: begin
        bwe = start && !in_mode && (done_r || (fill_r < FW'(BLOCK_BYTES)));
        if (done_r) bwa = '0;
      end
      lzhc_pkg::ST_HCLR: hwe = 1'b1;
      lzhc_pkg::ST_CLR:  rwe = 1'b1;
      lzhc_pkg::ST_PB:   bra = b_r[AW-1:0];
      lzhc_pkg::ST_CB:   bra = b_r[AW-1:0];
      lzhc_pkg::ST_INS: begin
        lwe = 1'b1; hwe = 1'b1; hwa = key_r; hwd = {1'b1, p_r[AW-1:0]};
      end
      lzhc_pkg::ST_STAMP: begin
        rwe = 1'b1; rwa = stamp_pos[AW-1:0];
        rwl = best_r - k_r; rws = bsrc_r + k_r[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lzhc_pkg::ST_HCLR; hc_r <= '0; rcnt_r <= '0;
      fill_r <= '0; done_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      unique case (st_r)
        lzhc_pkg::ST_IDLE: if (start) begin
          if (in_mode) begin
            rd_oor_r <= (FW'(in_read_index) >= FW'(BLOCK_BYTES));
            st_r <= lzhc_pkg::ST_RD;
          end else begin
            logic [FW-1:0] f;
            f = done_r ? '0 : fill_r;
            if (done_r) done_r <= 1'b0;
            if (f < FW'(BLOCK_BYTES)) f = f + 1'b1;
            fill_r <= f;
            if (in_last_byte) begin
              hc_r <= '0; rcnt_r <= '0; st_r <= lzhc_pkg::ST_HCLR;
              done_r <= 1'b1; p_r <= '0;
            end
          end
        end
        lzhc_pkg::ST_RD: st_r <= lzhc_pkg::ST_RDOUT;
        lzhc_pkg::ST_RDOUT: begin
          ov_r <= 1'b1;
          out_length <= rd_oor_r ? '0 : 15'(lq_len);
          out_match_position <= rd_oor_r ? '0 : 14'(lq_src);
          st_r <= lzhc_pkg::ST_IDLE;
        end
        lzhc_pkg::ST_HCLR: begin
          hc_r <= hc_r + 1'b1;
          if (hc_r == (HW+1)'(2**HW - 1)) st_r <= done_r ? lzhc_pkg::ST_CLR : lzhc_pkg::ST_CLR;
        end
        lzhc_pkg::ST_CLR: begin
          rcnt_r <= rcnt_r + 1'b1;
          if (rcnt_r == FW'(BLOCK_BYTES - 1)) begin
            p_r <= '0;
            st_r <= lzhc_pkg::ST_NEXT;
          end
        end
        lzhc_pkg::ST_NEXT: begin
          if (done_r && fill_r >= FW'(2) && p_r < fill_r - 1'b1) begin
            a_r <= p_r; b_r <= p_r + 1'b1; st_r <= lzhc_pkg::ST_PA;
          end else st_r <= lzhc_pkg::ST_IDLE;
        end
        lzhc_pkg::ST_PA: st_r <= lzhc_pkg::ST_PB;
        lzhc_pkg::ST_PB: begin ba_r <= bq; st_r <= lzhc_pkg::ST_HEAD; end
        lzhc_pkg::ST_HEAD: begin
          key_r <= {bq, ba_r}; st_r <= lzhc_pkg::ST_CHK;
          best_r <= '0; bsrc_r <= '0; hc_r <= '0;
        end
        lzhc_pkg::ST_CHK: begin
          if (hc_r == '0) begin
            hc_r <= (HW+1)'(1); st_r <= lzhc_pkg::ST_CHK;
          end else if (hc_r == (HW+1)'(1)) begin
            c_r <= hq; hd_r <= hq; hc_r <= (HW+1)'(2);
          end else if (hc_r == (HW+1)'(3)) begin
            c_r <= lq; hc_r <= (HW+1)'(2);
          end else if (valid_c) begin
            n_r <= FW'(2); a_r <= p_r + FW'(2); b_r <= FW'(c_r[AW-1:0]) + FW'(2);
            st_r <= lzhc_pkg::ST_CA;
          end else st_r <= lzhc_pkg::ST_INS;
        end
        lzhc_pkg::ST_CA: begin
          if (a_r < fill_r) st_r <= lzhc_pkg::ST_CB;
          else st_r <= lzhc_pkg::ST_CMP;
        end
        lzhc_pkg::ST_CB: begin ba_r <= bq; st_r <= lzhc_pkg::ST_LINK; end
        lzhc_pkg::ST_LINK: begin
          if (ba_r == bq) begin
            n_r <= n_r + 1'b1; a_r <= a_r + 1'b1; b_r <= b_r + 1'b1;
            st_r <= lzhc_pkg::ST_CA;
          end else st_r <= lzhc_pkg::ST_CMP;
        end
        lzhc_pkg::ST_CMP: begin
          if (n_r > best_r) begin best_r <= n_r; bsrc_r <= c_r[AW-1:0]; end
          hc_r <= (HW+1)'(3); st_r <= lzhc_pkg::ST_CHK;
        end
        lzhc_pkg::ST_INS: begin
          k_r <= '0;
          st_r <= (best_r > FW'(1)) ? lzhc_pkg::ST_STAMP : lzhc_pkg::ST_NEXT;
          if (best_r <= FW'(1)) p_r <= p_r + 1'b1;
        end
        lzhc_pkg::ST_STAMP: begin
          k_r <= k_r + 1'b1;
          if (k_r + 1'b1 == best_r) begin
            if (FW'(bsrc_r) + 1'b1 == p_r && best_r > FW'(RUN_KEEP))
              p_r <= p_r + best_r - FW'(RUN_KEEP) + 1'b1;
            else p_r <= p_r + 1'b1;
            st_r <= lzhc_pkg::ST_NEXT;
          end
        end
        default: st_r <= lzhc_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
endmodule

>>> hw/rtl/lzhc_checker.sv
module lzhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_mode,
  input logic        out_valid,
  input logic [14:0] out_length,
  input logic [13:0] out_match_position
);
  a_rd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> busy) else $error("read not taken");
  a_rd_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> ##2 out_valid) else $error("no read result");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_length == '0) |-> out_match_position == '0)
    else $error("position without length");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
endmodule

bind lz77_hash_chain_match_finder lzhc_checker u_chk (.*);
